// ===== rtl/core/wfmd_pkg.sv =====
// wfmd_pkg: shared constants, register codes and the quarter-wave sine table
// for the modulated delay core. No dependencies.
package wfmd_pkg;

	localparam int CHANNELS     = 2;
	localparam int SINE_ENTRIES = 1024;
	localparam int QUARTER      = SINE_ENTRIES / 4;
	localparam int SINE_IDX_W   = $clog2(QUARTER) + 1;
	localparam int SINE_BITS    = 15;
	localparam int PHASE_W      = 32;

	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;
	localparam int LEN_CFG_W    = 12;
	localparam int Q8_W         = 19;
	localparam int STEP_W       = 24;

	localparam int MIN_LENGTH   = 512;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH   = 3'd0,
		REG_BASE_DELAY     = 3'd1,
		REG_WOW_DEPTH      = 3'd2,
		REG_FLUTTER_DEPTH  = 3'd3,
		REG_WOW_STEP       = 3'd4,
		REG_FLUTTER_STEP   = 3'd5
	} cfg_reg_t;

	localparam logic [LEN_CFG_W-1:0] RST_DELAY_LENGTH  = 12'd1200;
	localparam logic [Q8_W-1:0]      RST_BASE_DELAY    = 19'd138240;
	localparam logic [Q8_W-1:0]      RST_WOW_DEPTH     = 19'd43008;
	localparam logic [Q8_W-1:0]      RST_FLUTTER_DEPTH = 19'd14746;
	localparam logic [STEP_W-1:0]    RST_WOW_STEP      = 24'd67109;
	localparam logic [STEP_W-1:0]    RST_FLUTTER_STEP  = 24'd984263;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [QUARTER:0][SINE_BITS-1:0] sine_tab_t;

	// odd taylor series to degree 9 in q30, truncating at each step
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		logic [63:0] x, x2, t, s, q;
		for (int j = 0; j <= QUARTER; j++) begin
			x  = (64'(j) * HALF_PI_Q30) / 64'(QUARTER);
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 64'd72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			tab[j] = SINE_BITS'(q);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/core/wfmd_ram.sv =====
// wfmd_ram: generic single write port, single read port memory with a
// registered read. No dependencies.
module wfmd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/wow_flutter_modulated_delay_core.sv =====
// wow_flutter_modulated_delay_core: stereo delay line with a read tap swung by
// two sine oscillators, linear interpolation between taps.
// Depends on wfmd_pkg and wfmd_ram.
//
//  port group   | dir | item
//  s_t*         | in  | one stereo frame, tdata = left_in, right_in
//  m_t*         | out | one stereo frame, tdata = left_out, right_out
//  cfg_*        | in  | register write, index and data
//
// a sequencer walks one shared multiplier through both depth products and the
// per-channel interpolations, and the delay memory gives one read per cycle.
// a new item is not accepted until the sequencer is back in idle.
// after reset the memory is swept to zero, ready low.
// a finished item waits in the output register; a new item is accepted meanwhile,
// and the sequencer holds in its last step while that register is full and not taken.
module wow_flutter_modulated_delay_core #(
	parameter int DELAY_DEPTH = 2048,
	parameter int SAMPLE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                             cfg_we,
	input  logic [wfmd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wfmd_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic s_tvalid,
	output logic s_tready,
	// left_in, right_in, zero pad
	input  logic [((wfmd_pkg::CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// left_out, right_out, zero pad
	output logic [((wfmd_pkg::CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

	import wfmd_pkg::*;

	localparam int AW    = $clog2(DELAY_DEPTH);
	localparam int LEN_W = AW + 1;
	localparam int CW    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
	localparam int ROW_W = CHANNELS * SAMPLE_BITS;
	localparam int TD_W  = ((ROW_W + 7) / 8) * 8;
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MA_W  = (SAMPLE_BITS + 1 > SINE_BITS + 1) ? SAMPLE_BITS + 1 : SINE_BITS + 1;
	localparam int MB_W  = Q8_W + 1;
	localparam int P_W   = MA_W + MB_W;
	localparam int S_W   = SINE_BITS + 1 + MB_W + 1;
	localparam int M_W   = S_W - 15;
	localparam int D_W   = (LEN_W + 9 > M_W + 1) ? LEN_W + 9 : M_W + 1;
	localparam int T_W   = LEN_W + 9;
	localparam int I_W   = SAMPLE_BITS + 10;

	localparam logic signed [S_W-1:0] RND15 = S_W'(16384);
	localparam logic signed [I_W-1:0] RND8  = I_W'(128);

	typedef enum logic [13:0] {
		ST_CLEAR = 14'b00000000000001,
		ST_IDLE  = 14'b00000000000010,
		ST_MW    = 14'b00000000000100,
		ST_MF    = 14'b00000000001000,
		ST_SUM   = 14'b00000000010000,
		ST_DLY   = 14'b00000000100000,
		ST_ADR   = 14'b00000001000000,
		ST_IDX   = 14'b00000010000000,
		ST_RD0   = 14'b00000100000000,
		ST_RD1   = 14'b00001000000000,
		ST_RD2   = 14'b00010000000000,
		ST_MUL   = 14'b00100000000000,
		ST_ACC   = 14'b01000000000000,
		ST_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [LEN_CFG_W-1:0] len_cfg_q;
	logic [Q8_W-1:0]      base_q, wdep_q, fdep_q;
	logic [STEP_W-1:0]    wstep_q, fstep_q;

	logic [PHASE_W-1:0]   wow_ph_q, flt_ph_q;
	logic [AW-1:0]        wp_q, clr_q, i0_q;
	logic [LEN_W-1:0]     len_q;
	logic [ROW_W-1:0]     in_row_q, s0_q, s1_q, res_q, out_data_q;
	logic                 out_valid_q;
	logic [CH_W-1:0]      ch_q;
	logic signed [SINE_BITS:0] sin_w_q, sin_f_q;
	logic signed [P_W-1:0] prod_q;
	logic signed [S_W-1:0] acc_q, sum_q;
	logic [LEN_W+7:0]     delay_q;
	logic [T_W-1:0]       t_q;
	logic [7:0]           frac_q;

	logic [CW-1:0]        len_ext;
	logic [LEN_W-1:0]     len_c;
	logic [AW-1:0]        wp_fix, i1, raddr, waddr;
	logic [ROW_W-1:0]     wdata, rd_data;
	logic                 we;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [SAMPLE_BITS-1:0] s0c, s1c;
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [M_W-1:0] mod_v;
	logic signed [D_W-1:0] d_raw;
	logic [LEN_W+7:0]     maxd;
	logic [LEN_W:0]       t_idx;
	logic signed [I_W-1:0] acc_i;
	logic                 accept, out_load;

	function automatic logic signed [SINE_BITS:0] sine_of(input logic [PHASE_W-1:0] ph);
		logic [SINE_IDX_W-1:0] j;
		logic [SINE_BITS-1:0]  mag;
		j = {1'b0, ph[PHASE_W-3 -: SINE_IDX_W-1]};
		if (ph[PHASE_W-2]) begin
			j = SINE_IDX_W'(QUARTER) - j;
		end
		mag = SINE_TAB[j];
		return ph[PHASE_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = TD_W'(out_data_q);

	// clamp length to the supported range
	always_comb begin
		len_ext = CW'(len_cfg_q);
		if (len_ext < CW'(MIN_LENGTH)) begin
			len_c = LEN_W'(MIN_LENGTH);
		end else if (len_ext > CW'(DELAY_DEPTH)) begin
			len_c = LEN_W'(DELAY_DEPTH);
		end else begin
			len_c = LEN_W'(len_ext);
		end
		wp_fix = (LEN_W'(wp_q) >= len_c) ? '0 : wp_q;
	end

	always_comb begin
		s0c  = $signed(s0_q[ch_q*SAMPLE_BITS +: SAMPLE_BITS]);
		s1c  = $signed(s1_q[ch_q*SAMPLE_BITS +: SAMPLE_BITS]);
		diff = (SAMPLE_BITS+1)'(s1c) - (SAMPLE_BITS+1)'(s0c);
		unique case (state_q)
			ST_MW: begin
				mul_a = MA_W'(sin_w_q);
				mul_b = $signed({1'b0, wdep_q});
			end
			ST_MF: begin
				mul_a = MA_W'(sin_f_q);
				mul_b = $signed({1'b0, fdep_q});
			end
			default: begin
				mul_a = MA_W'(diff);
				mul_b = $signed(MB_W'(frac_q));
			end
		endcase
	end

	always_comb begin
		mod_v = sum_q[S_W-1:15];
		d_raw = $signed(D_W'({1'b0, base_q})) + D_W'(mod_v);
		maxd  = {len_q - LEN_W'(2), 8'h00};
		t_idx = t_q[T_W-1:8];
		i1    = (LEN_W'(i0_q) + LEN_W'(1) == len_q) ? '0 : i0_q + AW'(1);
		raddr = (state_q == ST_RD1) ? i1 : i0_q;
		acc_i = (I_W'(s0c) <<< 8) + I_W'($signed(prod_q[I_W-1:0])) + RND8;
		we    = (state_q == ST_CLEAR) || (state_q == ST_MW);
		waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
		wdata = (state_q == ST_CLEAR) ? '0 : in_row_q;
	end

	wfmd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (DELAY_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= RST_DELAY_LENGTH;
			base_q    <= RST_BASE_DELAY;
			wdep_q    <= RST_WOW_DEPTH;
			fdep_q    <= RST_FLUTTER_DEPTH;
			wstep_q   <= RST_WOW_STEP;
			fstep_q   <= RST_FLUTTER_STEP;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DELAY_LENGTH:  len_cfg_q <= cfg_data[LEN_CFG_W-1:0];
				REG_BASE_DELAY:    base_q    <= cfg_data[Q8_W-1:0];
				REG_WOW_DEPTH:     wdep_q    <= cfg_data[Q8_W-1:0];
				REG_FLUTTER_DEPTH: fdep_q    <= cfg_data[Q8_W-1:0];
				REG_WOW_STEP:      wstep_q   <= cfg_data[STEP_W-1:0];
				REG_FLUTTER_STEP:  fstep_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wow_ph_q    <= '0;
			flt_ph_q    <= '0;
			wp_q        <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DELAY_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						wp_q    <= wp_fix;
						state_q <= ST_MW;
					end
				end
				ST_MW:  state_q <= ST_MF;
				ST_MF:  state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DLY;
				ST_DLY: state_q <= ST_ADR;
				ST_ADR: state_q <= ST_IDX;
				ST_IDX: state_q <= ST_RD0;
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					ch_q    <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (ch_q == CH_W'(CHANNELS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						wow_ph_q <= wow_ph_q + PHASE_W'(wstep_q);
						flt_ph_q <= flt_ph_q + PHASE_W'(fstep_q);
						wp_q     <= (LEN_W'(wp_q) + LEN_W'(1) >= len_q) ? '0 : wp_q + AW'(1);
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			len_q    <= len_c;
			in_row_q <= s_tdata[ROW_W-1:0];
			sin_w_q  <= sine_of(wow_ph_q);
			sin_f_q  <= sine_of(flt_ph_q);
		end
		if (state_q == ST_MF) begin
			acc_q <= $signed(prod_q[S_W-1:0]);
		end
		if (state_q == ST_SUM) begin
			sum_q <= acc_q + $signed(prod_q[S_W-1:0]) + RND15;
		end
		if (state_q == ST_DLY) begin
			if (d_raw < 0) begin
				delay_q <= '0;
			end else if (d_raw > $signed(D_W'({1'b0, maxd}))) begin
				delay_q <= maxd;
			end else begin
				delay_q <= d_raw[LEN_W+7:0];
			end
		end
		if (state_q == ST_ADR) begin
			t_q <= T_W'({wp_q, 8'h00}) + T_W'({len_q, 8'h00}) - T_W'(delay_q);
		end
		if (state_q == ST_IDX) begin
			i0_q   <= (t_idx >= (LEN_W+1)'(len_q)) ? AW'(t_idx - (LEN_W+1)'(len_q))
			                                        : AW'(t_idx);
			frac_q <= t_q[7:0];
		end
		if (state_q == ST_RD1) begin
			s0_q <= rd_data;
		end
		if (state_q == ST_RD2) begin
			s1_q <= rd_data;
		end
		if (state_q == ST_ACC) begin
			res_q[ch_q*SAMPLE_BITS +: SAMPLE_BITS] <= acc_i[SAMPLE_BITS+7:8];
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

endmodule

// ===== rtl/core/wfmd_checker.sv =====
// wfmd_checker: port-level checks on the modulated delay core, bound to the
// top level below. Depends on wow_flutter_modulated_delay_core.
module wfmd_checker #(
	parameter int DATA_W = 48
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// an accepted item keeps the sequencer busy and ready low
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("ready came back too soon after an accept");

	// a new result appears only as the sequencer returns to idle
	a_result_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result posted while sequencer still busy");

	// while the sequencer is idle, a new result can not follow a taken one in the next cycle
	a_no_double_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && s_tready |=> !m_tvalid)
		else $error("result posted with no item in progress");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped or changed");

endmodule

bind wow_flutter_modulated_delay_core wfmd_checker #(
	.DATA_W ($bits(m_tdata))
) u_wfmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/wow_flutter_modulated_delay_core_tb.sv =====
`timescale 1ns / 1ps
// wow_flutter_modulated_delay_core_tb: directed table and random frames through the
// modulated delay core, checked frame by frame against a predictor in this file
// or the table's own expected frames. Depends on wfmd_pkg and the core.
module wow_flutter_modulated_delay_core_tb;
	import wfmd_pkg::*;

	localparam int SAMPLE_W    = 24;
	localparam int TDATA_W     = ((CHANNELS * SAMPLE_W + 7) / 8) * 8;
	localparam int LINE_DEPTH  = 2048;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_AFTER  = 200;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct {
		sample_t left;
		sample_t right;
	} frame_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		sample_t               left;
		sample_t               right;
		bit                    typed;
		sample_t               want_l;
		sample_t               want_r;
	} stim_row_t;

	typedef enum {SINK_OPEN, SINK_RANDOM, SINK_SHUT} sink_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	// left_in, right_in
	logic [TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// left_out, right_out
	logic [TDATA_W-1:0] m_tdata;

	// predictor copy of the registers and the line state
	logic [LEN_CFG_W-1:0] line_len;
	logic [Q8_W-1:0]      base_delay;
	logic [Q8_W-1:0]      wow_depth;
	logic [Q8_W-1:0]      flut_depth;
	logic [STEP_W-1:0]    wow_step;
	logic [STEP_W-1:0]    flut_step;
	logic [31:0]          wow_ph;
	logic [31:0]          flut_ph;
	int unsigned          wr_pos;
	sample_t              line_l [LINE_DEPTH];
	sample_t              line_r [LINE_DEPTH];

	frame_t frames_due[$];
	int     mismatches;

	stim_row_t directed_rows [27] = '{
		'{1'b0, 3'd0, 24'd0, 24'h7FFFFF, 24'h800000, 1'b1, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h800000, 24'h7FFFFF, 1'b1, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h000000, 24'h000000, 1'b1, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'hFFFFFF, 24'h000001, 1'b1, 24'd0, 24'd0},
		// zero delay: the frame comes straight back
		'{1'b1, REG_BASE_DELAY, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b1, REG_WOW_DEPTH, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b1, REG_FLUTTER_DEPTH, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h7FFFFF, 24'h800000, 1'b1, 24'h7FFFFF, 24'h800000},
		'{1'b0, 3'd0, 24'd0, 24'h800000, 24'h7FFFFF, 1'b1, 24'h800000, 24'h7FFFFF},
		'{1'b0, 3'd0, 24'd0, 24'hFFFFFF, 24'h000000, 1'b1, 24'hFFFFFF, 24'h000000},
		'{1'b0, 3'd0, 24'd0, 24'h555555, 24'hAAAAAA, 1'b1, 24'h555555, 24'hAAAAAA},
		// half sample delay
		'{1'b1, REG_BASE_DELAY, 24'd128, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h800000, 24'h800000, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h7FFFFF, 24'h800000, 1'b0, 24'd0, 24'd0},
		// shortest line, everything else at full scale
		'{1'b1, REG_DELAY_LENGTH, 24'd512, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b1, REG_BASE_DELAY, 24'h07FFFF, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b1, REG_WOW_DEPTH, 24'h07FFFF, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b1, REG_FLUTTER_DEPTH, 24'h07FFFF, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b1, REG_WOW_STEP, 24'hFFFFFF, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b1, REG_FLUTTER_STEP, 24'hFFFFFF, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h123456, 24'hFEDCBA, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h800000, 24'h7FFFFF, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h7FFFFF, 24'h000000, 1'b0, 24'd0, 24'd0},
		// write to an index with no register
		'{1'b1, REG_UNUSED, 24'hABCDEF, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h000001, 24'hFFFFFF, 1'b0, 24'd0, 24'd0},
		'{1'b0, 3'd0, 24'd0, 24'h400000, 24'hC00000, 1'b0, 24'd0, 24'd0}
	};

	wow_flutter_modulated_delay_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// q1.15 sine of the table entry picked by the top bits of the phase
	function automatic longint sine_q15(logic [31:0] ph);
		longint unsigned k, quad, rem, x, x2, t, s, q;
		k = ph[31:22];
		quad = k >> 8;
		rem = (k * 4) % 1024;
		if (quad == 1 || quad == 3) begin
			rem = 1024 - rem;
		end
		x  = rem * HALF_PI_Q30 / 1024;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		q  = (s * 32767 + (64'd1 << 29)) >> 30;
		if (q > 32767) begin
			q = 32767;
		end
		return (quad >= 2) ? -longint'(q) : longint'(q);
	endfunction

	function automatic sample_t blend(sample_t a, sample_t b, int f);
		longint acc;
		acc = longint'(a) * (256 - f) + longint'(b) * f + 128;
		return sample_t'(acc >>> 8);
	endfunction

	function automatic frame_t next_delayed_frame(sample_t l, sample_t r);
		longint unsigned eff_len, tap, i0, i1, frac;
		longint swing, dly, maxd;
		frame_t res;
		eff_len = line_len;
		if (eff_len < MIN_LENGTH) begin
			eff_len = MIN_LENGTH;
		end
		if (eff_len > LINE_DEPTH) begin
			eff_len = LINE_DEPTH;
		end
		if (wr_pos >= eff_len) begin
			wr_pos = 0;
		end
		swing = sine_q15(wow_ph) * longint'(wow_depth)
			+ sine_q15(flut_ph) * longint'(flut_depth);
		swing = (swing + 64'sd16384) >>> 15;
		dly = longint'(base_delay) + swing;
		maxd = longint'(eff_len - 2) * 256;
		if (dly < 0) begin
			dly = 0;
		end
		if (dly > maxd) begin
			dly = maxd;
		end
		tap  = wr_pos * 256 + eff_len * 256 - dly;
		i0   = (tap >> 8) % eff_len;
		i1   = (i0 + 1) % eff_len;
		frac = tap & 255;
		line_l[wr_pos] = l;
		line_r[wr_pos] = r;
		res.left  = blend(line_l[i0], line_l[i1], int'(frac));
		res.right = blend(line_r[i0], line_r[i1], int'(frac));
		wow_ph  = wow_ph + wow_step;
		flut_ph = flut_ph + flut_step;
		wr_pos++;
		if (wr_pos >= eff_len) begin
			wr_pos = 0;
		end
		return res;
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(0, 15))
			0: begin
				return 24'h7FFFFF;
			end
			1: begin
				return 24'h800000;
			end
			2: begin
				return 24'h000000;
			end
			3: begin
				return 24'hFFFFFF;
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_DELAY_LENGTH: begin
				line_len = val[LEN_CFG_W-1:0];
			end
			REG_BASE_DELAY: begin
				base_delay = val[Q8_W-1:0];
			end
			REG_WOW_DEPTH: begin
				wow_depth = val[Q8_W-1:0];
			end
			REG_FLUTTER_DEPTH: begin
				flut_depth = val[Q8_W-1:0];
			end
			REG_WOW_STEP: begin
				wow_step = val[STEP_W-1:0];
			end
			REG_FLUTTER_STEP: begin
				flut_step = val[STEP_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic offer_frame(input sample_t l, input sample_t r, input bit typed,
			input frame_t want);
		frame_t pred;
		s_tvalid <= 1'b1;
		s_tdata  <= {r, l};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pred = next_delayed_frame(l, r);
		frames_due.push_back(typed ? want : pred);
	endtask

	task automatic idle_sender();
		int pick, gap;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			gap = 0;
		end else if (pick < 92) begin
			gap = $urandom_range(1, 5);
		end else begin
			gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_frames();
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		stim_row_t row;
		frame_t want;
		logic [CFG_DATA_W-1:0] len_v, base_v, wow_v, flut_v, ws_v, fs_v;
		int n_items;
		line_len   = RST_DELAY_LENGTH;
		base_delay = RST_BASE_DELAY;
		wow_depth  = RST_WOW_DEPTH;
		flut_depth = RST_FLUTTER_DEPTH;
		wow_step   = RST_WOW_STEP;
		flut_step  = RST_FLUTTER_STEP;
		wow_ph     = '0;
		flut_ph    = '0;
		wr_pos     = 0;
		mismatches = 0;
		foreach (line_l[i]) begin
			line_l[i] = '0;
			line_r[i] = '0;
		end
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				drain_frames();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				want.left  = row.want_l;
				want.right = row.want_r;
				offer_frame(row.left, row.right, row.typed, want);
				idle_sender();
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain_frames();
			ws_v = 24'($urandom);
			fs_v = 24'($urandom);
			n_items = 100;
			case (ph)
				0: begin
					len_v  = 24'd512;
					base_v = $urandom_range(0, 40000);
					wow_v  = $urandom_range(0, 60000);
					flut_v = $urandom_range(0, 30000);
				end
				1: begin
					len_v  = 24'd2048;
					base_v = 24'h07FFFF;
					wow_v  = 24'h07FFFF;
					flut_v = 24'h07FFFF;
					ws_v   = 24'hFFFFFF;
					fs_v   = 24'hFFFFFF;
					n_items = 400;
				end
				2: begin
					len_v  = $urandom_range(700, 2047);
					base_v = 24'($urandom);
					wow_v  = 24'($urandom);
					flut_v = 24'($urandom);
				end
				3: begin
					// below the shortest line, and the write position past its end
					len_v  = $urandom_range(0, 511);
					base_v = $urandom_range(0, 130000);
					wow_v  = $urandom_range(0, 80000);
					flut_v = $urandom_range(0, 80000);
					fs_v   = 24'd0;
				end
				4: begin
					len_v  = {12'($urandom), 12'($urandom_range(2049, 4095))};
					base_v = $urandom_range(0, 524287);
					wow_v  = $urandom_range(0, 524287);
					flut_v = $urandom_range(0, 524287);
				end
				default: begin
					len_v  = $urandom_range(512, 2048);
					base_v = 24'd0;
					wow_v  = 24'h07FFFF;
					flut_v = 24'h07FFFF;
					ws_v   = 24'd0;
				end
			endcase
			write_reg(REG_DELAY_LENGTH, len_v);
			write_reg(REG_BASE_DELAY, base_v);
			write_reg(REG_WOW_DEPTH, wow_v);
			write_reg(REG_FLUTTER_DEPTH, flut_v);
			write_reg(REG_WOW_STEP, ws_v);
			write_reg(REG_FLUTTER_STEP, fs_v);
			for (int n = 0; n < n_items; n++) begin
				offer_frame(random_sample(), random_sample(), 1'b0, want);
				idle_sender();
			end
		end

		drain_frames();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && frames_due.size() == 0) begin
			$display("wow_flutter_modulated_delay_core: match");
		end else begin
			$display("wow_flutter_modulated_delay_core: mismatch");
		end
		$finish;
	end

	initial begin : result_sink
		frame_t want;
		sample_t got_l, got_r;
		sink_mode_t sink_mode;
		int stretch_left, hold_left, received, pick;
		bit hold_done;
		sink_mode = SINK_OPEN;
		stretch_left = 0;
		hold_left = 0;
		received = 0;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got_l = m_tdata[SAMPLE_W-1:0];
				got_r = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
				received++;
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected item, left_out %0d right_out %0d",
						$time, got_l, got_r);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					if (got_l !== want.left) begin
						$display("%0t: left_out expected %0d got %0d", $time, want.left, got_l);
						mismatches++;
					end
					if (got_r !== want.right) begin
						$display("%0t: right_out expected %0d got %0d", $time, want.right, got_r);
						mismatches++;
					end
				end
			end
			// one long hold so the core fills up and stalls its input
			if (!hold_done && received == HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stretch_left == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					sink_mode = SINK_OPEN;
					stretch_left = $urandom_range(10, 100);
				end else if (pick < 92) begin
					sink_mode = SINK_RANDOM;
					stretch_left = $urandom_range(10, 60);
				end else begin
					sink_mode = SINK_SHUT;
					stretch_left = $urandom_range(20, 80);
				end
			end
			stretch_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_OPEN: begin
						m_tready <= 1'b1;
					end
					SINK_RANDOM: begin
						m_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_tready <= 1'b0;
					end
				endcase
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("wow_flutter_modulated_delay_core: mismatch");
		$finish;
	end

endmodule
